/* rtl/core/wav_header_validator_top_macros.svh */
// Assertion macros for the WAV header validator.
`ifndef WAV_HEADER_VALIDATOR_TOP_MACROS_SVH
`define WAV_HEADER_VALIDATOR_TOP_MACROS_SVH

// Checked at every edge outside reset.
`define WAVHV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define WAVHV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/core/wavhv_pkg.sv */
package wavhv_pkg;

  localparam int unsigned HdrLen = 44;
  localparam logic [5:0] LastPos = 6'(HdrLen - 1);

  // Field offsets in the canonical header.
  localparam logic [5:0] FmtSizeBase = 6'd16;
  localparam logic [5:0] FmtCodeBase = 6'd20;
  localparam logic [5:0] ChanBase    = 6'd22;
  localparam logic [5:0] RateBase    = 6'd24;
  localparam logic [5:0] ByteRtBase  = 6'd28;
  localparam logic [5:0] AlignBase   = 6'd32;
  localparam logic [5:0] BitsBase    = 6'd34;
  localparam logic [5:0] DataSzBase  = 6'd40;

  localparam logic [31:0] FmtChunkPcm = 32'd16;
  localparam logic [15:0] FmtCodePcm  = 16'd1;
  localparam logic [31:0] MaxRate     = 32'd192000;
  localparam logic [15:0] Bits8       = 16'd8;
  localparam logic [15:0] Bits16      = 16'd16;

  // Assembled header fields handed to the checker.
  typedef struct packed {
    logic        tags_ok;
    logic [31:0] fmt_chunk_len;
    logic [15:0] fmt_code;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits;
    logic [31:0] payload_len;
  } hdr_fields_t;

  // Idle state of the field registers: all fields zero, tags still matching.
  localparam hdr_fields_t FieldsClear = '{
    tags_ok:       1'b1,
    fmt_chunk_len: 32'd0,
    fmt_code:      16'd0,
    channels:      16'd0,
    rate:          32'd0,
    byte_rate:     32'd0,
    block_align:   16'd0,
    bits:          16'd0,
    payload_len:   32'd0
  };

  typedef struct packed {
    logic        valid;
    logic [31:0] frames;
  } hdr_verdict_t;

  // Replace one byte lane of a little-endian word.
  function automatic logic [31:0] put_lane(logic [31:0] f, logic [1:0] lane, logic [7:0] b);
    logic [31:0] r;
    r = f;
    case (lane)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r[31:24] = b;
    endcase
    return r;
  endfunction

  // Expected tag character at a tag offset; is_tag low elsewhere.
  function automatic logic [8:0] tag_char(logic [5:0] pos);
    logic [8:0] r;
    unique case (pos)
      6'd0:    r = {1'b1, 8'h52}; // R
      6'd1:    r = {1'b1, 8'h49}; // I
      6'd2:    r = {1'b1, 8'h46}; // F
      6'd3:    r = {1'b1, 8'h46}; // F
      6'd8:    r = {1'b1, 8'h57}; // W
      6'd9:    r = {1'b1, 8'h41}; // A
      6'd10:   r = {1'b1, 8'h56}; // V
      6'd11:   r = {1'b1, 8'h45}; // E
      6'd12:   r = {1'b1, 8'h66}; // f
      6'd13:   r = {1'b1, 8'h6d}; // m
      6'd14:   r = {1'b1, 8'h74}; // t
      6'd15:   r = {1'b1, 8'h20}; // space
      6'd36:   r = {1'b1, 8'h64}; // d
      6'd37:   r = {1'b1, 8'h61}; // a
      6'd38:   r = {1'b1, 8'h74}; // t
      6'd39:   r = {1'b1, 8'h61}; // a
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/wavhv_check.sv */
module wavhv_check import wavhv_pkg::*; (
  input  hdr_fields_t  fields_i,
  output hdr_verdict_t verdict_o
);

  logic        fmt_ok;
  logic        chan_ok;
  logic        bits_ok;
  logic        rate_ok;
  logic [1:0]  shift;
  logic [33:0] exp_byte_rate;
  logic [15:0] exp_align;
  logic        all_ok;

  always_comb begin
    fmt_ok  = (fields_i.fmt_chunk_len == FmtChunkPcm) && (fields_i.fmt_code == FmtCodePcm);
    chan_ok = (fields_i.channels == 16'd1) || (fields_i.channels == 16'd2);
    bits_ok = (fields_i.bits == Bits8) || (fields_i.bits == Bits16);
    rate_ok = (fields_i.rate != 32'd0) && (fields_i.rate <= MaxRate);
    // bytes per sample times channels is 1, 2 or 4 once the fields pass
    shift = {1'b0, fields_i.bits == Bits16} + {1'b0, fields_i.channels == 16'd2};
    exp_byte_rate = {2'b00, fields_i.rate} << shift;
    exp_align     = 16'd1 << shift;
    all_ok = fields_i.tags_ok && fmt_ok && chan_ok && bits_ok && rate_ok &&
             (exp_byte_rate == {2'b00, fields_i.byte_rate}) &&
             (fields_i.block_align == exp_align);
    verdict_o.valid  = all_ok;
    verdict_o.frames = all_ok ? (fields_i.payload_len >> shift) : 32'd0;
  end

endmodule

/* rtl/core/wav_header_validator_top.sv */
// WAV header validator. Feed the 44-byte canonical RIFF/WAVE header one byte
// per transfer, flagging offset zero with first_byte_i; a flagged byte restarts
// parsing at any time, and unflagged bytes outside a header are taken and
// dropped. The byte at offset 43 produces one result: header_valid_o, the
// channel, bit-depth and rate fields as read, and frame_count_o (data size
// over block alignment, zero when invalid). The field registers, tag compare
// and checker sit in one stage in front of the result register, so a byte is
// taken every cycle while the result register is empty or being drained. A
// pending result stalls input only if it is not taken.
`include "wav_header_validator_top_macros.svh"

module wav_header_validator_top import wavhv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  header_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        header_valid_o,
  output logic [15:0] channel_count_o,
  output logic [15:0] sample_bits_o,
  output logic [31:0] sample_rate_o,
  output logic [31:0] frame_count_o
);

  logic        in_fire;
  logic        active;
  logic [5:0]  pos;
  logic [8:0]  tag;
  logic        last;

  logic [5:0]  byte_pos_q, byte_pos_d;
  hdr_fields_t fld_q, fld_d;
  hdr_fields_t base;
  hdr_verdict_t verdict;

  logic        out_valid_q, out_valid_d;
  logic        hv_q;
  logic [15:0] chan_q;
  logic [15:0] bits_q;
  logic [31:0] rate_q;
  logic [31:0] frames_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  // Idle bytes are taken but do nothing.
  assign active     = first_byte_i || (byte_pos_q != 6'd0);
  assign pos        = first_byte_i ? 6'd0 : byte_pos_q;
  assign tag        = tag_char(pos);
  assign last       = (pos == LastPos);

  // Field assembly; a first byte starts from cleared fields.
  always_comb begin
    base = fld_q;
    if (first_byte_i) begin
      base = '0;
      base.tags_ok = 1'b1;
    end
    fld_d = base;
    if (tag[8] && (tag[7:0] != header_byte_i)) begin
      fld_d.tags_ok = 1'b0;
    end
    case (pos) inside
      [6'd16:6'd19]: fld_d.fmt_chunk_len = put_lane(base.fmt_chunk_len,
                                                    2'(pos - FmtSizeBase), header_byte_i);
      [6'd20:6'd21]: fld_d.fmt_code = 16'(put_lane({16'd0, base.fmt_code},
                                                   2'(pos - FmtCodeBase), header_byte_i));
      [6'd22:6'd23]: fld_d.channels = 16'(put_lane({16'd0, base.channels},
                                                   2'(pos - ChanBase), header_byte_i));
      [6'd24:6'd27]: fld_d.rate = put_lane(base.rate, 2'(pos - RateBase), header_byte_i);
      [6'd28:6'd31]: fld_d.byte_rate = put_lane(base.byte_rate, 2'(pos - ByteRtBase),
                                                header_byte_i);
      [6'd32:6'd33]: fld_d.block_align = 16'(put_lane({16'd0, base.block_align},
                                                      2'(pos - AlignBase), header_byte_i));
      [6'd34:6'd35]: fld_d.bits = 16'(put_lane({16'd0, base.bits},
                                               2'(pos - BitsBase), header_byte_i));
      [6'd40:6'd43]: fld_d.payload_len = put_lane(base.payload_len, 2'(pos - DataSzBase),
                                                  header_byte_i);
      default: ;
    endcase
  end

  // The checker sees the fields including this cycle's byte.
  wavhv_check u_check (
    .fields_i  (fld_d),
    .verdict_o (verdict)
  );

  always_comb begin
    byte_pos_d = byte_pos_q;
    if (in_fire && active) begin
      byte_pos_d = last ? 6'd0 : pos + 6'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && active && last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Field registers; cleared at reset to match the idle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q <= FieldsClear;
    end else if (in_fire && active) begin
      fld_q <= fld_d;
    end
  end

  // Result register, loaded on the last header byte.
  always_ff @(posedge clk_i) begin
    if (in_fire && active && last) begin
      hv_q     <= verdict.valid;
      chan_q   <= fld_d.channels;
      bits_q   <= fld_d.bits;
      rate_q   <= fld_d.rate;
      frames_q <= verdict.frames;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign header_valid_o  = hv_q;
  assign channel_count_o = chan_q;
  assign sample_bits_o   = bits_q;
  assign sample_rate_o   = rate_q;
  assign frame_count_o   = frames_q;

  `WAVHV_ASSERT(a_last_byte_gives_result, (in_fire && active && last) |=> out_valid_q, "last header byte gave no result")
  `WAVHV_ASSERT(a_invalid_zero_frames, (out_valid_o && !header_valid_o) |-> (frame_count_o == 32'd0), "frame count nonzero on invalid header")
  `WAVHV_ASSERT(a_valid_channels, (out_valid_o && header_valid_o) |-> ((channel_count_o == 16'd1) || (channel_count_o == 16'd2)), "valid header with bad channel count")
  `WAVHV_ASSERT_ALWAYS(a_pos_range, !rst_ni || (byte_pos_q <= LastPos), "byte position past header end")

endmodule
